/* design/qnp_pkg.sv */
// Shared types, constants and the square-root step for the quaternion product core.
`timescale 1ns / 1ps
package qnp_pkg;

    // Q1.14 unity
    localparam int ONE_Q14   = 16384;
    // Width of one component fed to a normalizer (magnitude up to 65536, signed)
    localparam int VW        = 18;
    // Width of one squared component and of the sum of four squares
    localparam int SQW       = 34;
    localparam int SW        = 35;
    // Width of the remainder and running product of the root recurrence
    localparam int RW        = 70;
    // Result digits of one normalized component (0..16384)
    localparam int NSTEP     = 15;
    // Normalizer latency: square, sum, init, one stage per digit, output
    localparam int NORM_LAT  = 3 + NSTEP + 1;
    // Product latency: partial products, sums, rounding
    localparam int PROD_LAT  = 3;
    // Start to done
    localparam int TOTAL_LAT = 2 * NORM_LAT + PROD_LAT;

    localparam logic KIND_MUL = 1'b0;
    localparam logic KIND_DIV = 1'b1;

    typedef logic signed [VW-1:0] comp_t;
    typedef logic signed [15:0]   q14_t;

    // Input word
    typedef struct packed {
        logic              kind;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
    } out_word_t;

    // State of one lane of the root recurrence
    //   rem = 4 t^2 - (2n-1)^2 s,  mac = (2n-1) s
    typedef struct packed {
        logic signed [RW-1:0] rem;
        logic signed [RW-1:0] mac;
        logic [NSTEP-1:0]     n;
    } root_t;

    // Try to set bit k of n; keep it if the remainder stays non-negative.
    function automatic root_t root_step(root_t st, logic [SW-1:0] s, logic [3:0] k);
        logic signed [RW-1:0] sx;
        logic signed [RW-1:0] t;
        logic signed [RW-1:0] d;
        logic signed [RW-1:0] rn;
        root_t                o;
        o  = st;
        sx = $signed({{(RW-SW){1'b0}}, s});
        t  = st.mac + (sx <<< k);
        d  = t <<< ({1'b0, k} + 5'd2);
        rn = st.rem - d;
        // once n reached unity no larger digit fits
        if (!st.n[NSTEP-1] && !rn[RW-1])
        begin
            o.rem = rn;
            o.n   = st.n | (NSTEP'(1) << k);
            o.mac = st.mac + (sx <<< ({1'b0, k} + 5'd1));
        end
        return o;
    endfunction

endpackage

/* design/qnp_norm.sv */
// Pipelined normalizer: four components to a Q1.14 unit quaternion.
`timescale 1ns / 1ps
module qnp_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qnp_pkg::comp_t      vec [4],
    input  logic [7:0]          thr,
    output logic                out_valid,
    output qnp_pkg::q14_t       res [4]
);

    localparam int NS = qnp_pkg::NSTEP;

    // stage 1: squares and signs
    logic                       v1_reg;
    logic [qnp_pkg::SQW-1:0]    sq1_reg  [4];
    logic [qnp_pkg::SQW-1:0]    sq1_next [4];
    logic [3:0]                 neg1_reg;
    // stage 2: sum of squares
    logic                       v2_reg;
    logic [qnp_pkg::SQW-1:0]    sq2_reg [4];
    logic [qnp_pkg::SW-1:0]     s2_reg;
    logic [qnp_pkg::SW-1:0]     s2_next;
    logic [3:0]                 neg2_reg;
    // root stages, index 0 is the initial state
    logic                       vr_reg   [NS+1];
    qnp_pkg::root_t             lane_reg [NS+1][4];
    logic [qnp_pkg::SW-1:0]     sr_reg   [NS+1];
    logic [3:0]                 negr_reg [NS+1];
    logic                       zr_reg   [NS+1];
    // output stage
    logic                       vo_reg;
    qnp_pkg::q14_t              res_reg  [4];

    always_comb
    begin
        logic signed [2*qnp_pkg::VW-1:0] p;
        for (int i = 0; i < 4; i++)
        begin
            p           = vec[i] * vec[i];
            sq1_next[i] = p[qnp_pkg::SQW-1:0];
        end
    end

    always_comb
    begin
        s2_next = '0;
        for (int i = 0; i < 4; i++)
            s2_next = s2_next + qnp_pkg::SW'(sq1_reg[i]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int g = 0; g <= NS; g++)
                vr_reg[g] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vr_reg[0] <= v2_reg;
            for (int g = 0; g < NS; g++)
                vr_reg[g+1] <= vr_reg[g];
            vo_reg    <= vr_reg[NS];
        end
    end

    // front stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq1_reg[i]  <= sq1_next[i];
            neg1_reg[i] <= vec[i][qnp_pkg::VW-1];
            sq2_reg[i]  <= sq1_reg[i];
        end
        s2_reg   <= s2_next;
        neg2_reg <= neg1_reg;
    end

    // init: rem = 4 (|v| 2^14)^2 - s, mac = -s, zero test
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane_reg[0][i].rem <= ($signed(qnp_pkg::RW'(sq2_reg[i])) <<< 30)
                                  - $signed(qnp_pkg::RW'(s2_reg));
            lane_reg[0][i].mac <= -$signed(qnp_pkg::RW'(s2_reg));
            lane_reg[0][i].n   <= '0;
        end
        sr_reg[0]   <= s2_reg;
        negr_reg[0] <= neg2_reg;
        zr_reg[0]   <= (s2_reg <= qnp_pkg::SW'(thr) * qnp_pkg::SW'(thr));
    end

    // one result digit per stage, most significant first
    for (genvar g = 0; g < NS; g++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 4; i++)
                lane_reg[g+1][i] <= qnp_pkg::root_step(lane_reg[g][i], sr_reg[g],
                                                       4'(NS - 1 - g));
            sr_reg[g+1]   <= sr_reg[g];
            negr_reg[g+1] <= negr_reg[g];
            zr_reg[g+1]   <= zr_reg[g];
        end
    end

    // sign and identity fallback
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (zr_reg[NS])
                res_reg[i] <= (i == 3) ? 16'(qnp_pkg::ONE_Q14) : 16'sd0;
            else if (negr_reg[NS][i])
                res_reg[i] <= -$signed({1'b0, lane_reg[NS][i].n});
            else
                res_reg[i] <= $signed({1'b0, lane_reg[NS][i].n});
        end
    end

    assign out_valid = vo_reg;
    assign res       = res_reg;

endmodule

/* design/qnp_hamilton.sv */
// Pipelined Hamilton product of two unit quaternions with Q.14 rounding.
`timescale 1ns / 1ps
module qnp_hamilton (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                kind,
    input  qnp_pkg::q14_t       na [4],
    input  qnp_pkg::q14_t       nb [4],
    output logic                out_valid,
    output qnp_pkg::comp_t      prod [4]
);

    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic signed [31:0]  pp_reg  [4][4];
    logic signed [31:0]  sum_reg [4];
    logic signed [31:0]  sum_next [4];
    qnp_pkg::comp_t      prod_reg [4];
    qnp_pkg::q14_t       nbc [4];

    // division uses the conjugate of b
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            nbc[j] = (kind == qnp_pkg::KIND_DIV && j != 3) ? -nb[j] : nb[j];
    end

    // component order x, y, z, w
    always_comb
    begin
        sum_next[0] = pp_reg[3][0] + pp_reg[0][3] + pp_reg[1][2] - pp_reg[2][1];
        sum_next[1] = pp_reg[3][1] - pp_reg[0][2] + pp_reg[1][3] + pp_reg[2][0];
        sum_next[2] = pp_reg[3][2] + pp_reg[0][1] - pp_reg[1][0] + pp_reg[2][3];
        sum_next[3] = pp_reg[3][3] - pp_reg[0][0] - pp_reg[1][1] - pp_reg[2][2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // partial products, sums, then round half away from zero to Q.14
    always_ff @(posedge clk)
    begin
        logic [31:0] m;
        logic [17:0] r;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                pp_reg[i][j] <= na[i] * nbc[j];
        for (int i = 0; i < 4; i++)
            sum_reg[i] <= sum_next[i];
        for (int i = 0; i < 4; i++)
        begin
            m = sum_reg[i][31] ? 32'(-sum_reg[i]) : 32'(sum_reg[i]);
            m = (m + 32'd8192) >> 14;
            r = (m > 32'd65536) ? 18'd65536 : m[17:0];
            prod_reg[i] <= sum_reg[i][31] ? -$signed(r) : $signed(r);
        end
    end

    assign out_valid = v3_reg;
    assign prod      = prod_reg;

endmodule

/* design/normalized_quaternion_product_core.sv */
// Top level of the normalized quaternion product core.
//
// Takes one word per cycle (busy is never raised) and returns each result
// word with done high for one cycle. The path is two 19-stage normalizers
// (square, sum, set-up, one stage per result digit of the root recurrence,
// sign) around a 3-stage Hamilton product. The zero threshold is read live,
// so write it only while no word is in flight.
`timescale 1ns / 1ps
module normalized_quaternion_product_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  qnp_pkg::in_word_t   operands,
    output logic                done,
    output qnp_pkg::out_word_t  result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data
);

    logic [7:0]          thr_reg;
    logic                kind_reg [qnp_pkg::NORM_LAT];
    qnp_pkg::comp_t      va [4];
    qnp_pkg::comp_t      vb [4];
    qnp_pkg::q14_t       na [4];
    qnp_pkg::q14_t       nb [4];
    qnp_pkg::comp_t      prod [4];
    qnp_pkg::q14_t       r [4];
    logic                accept;
    logic                na_valid;
    logic                nb_valid;
    logic                prod_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // zero threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 8'd1;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    assign va[0] = qnp_pkg::VW'(operands.a_x);
    assign va[1] = qnp_pkg::VW'(operands.a_y);
    assign va[2] = qnp_pkg::VW'(operands.a_z);
    assign va[3] = qnp_pkg::VW'(operands.a_w);
    assign vb[0] = qnp_pkg::VW'(operands.b_x);
    assign vb[1] = qnp_pkg::VW'(operands.b_y);
    assign vb[2] = qnp_pkg::VW'(operands.b_z);
    assign vb[3] = qnp_pkg::VW'(operands.b_w);

    // kind rides alongside the operand normalizers
    always_ff @(posedge clk)
    begin
        kind_reg[0] <= operands.kind;
        for (int i = 1; i < qnp_pkg::NORM_LAT; i++)
            kind_reg[i] <= kind_reg[i-1];
    end

    qnp_norm u_norm_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec       (va),
        .thr       (thr_reg),
        .out_valid (na_valid),
        .res       (na)
    );

    qnp_norm u_norm_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec       (vb),
        .thr       (thr_reg),
        .out_valid (nb_valid),
        .res       (nb)
    );

    qnp_hamilton u_ham (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (na_valid && nb_valid),
        .kind      (kind_reg[qnp_pkg::NORM_LAT-1]),
        .na        (na),
        .nb        (nb),
        .out_valid (prod_valid),
        .prod      (prod)
    );

    qnp_norm u_norm_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .vec       (prod),
        .thr       (thr_reg),
        .out_valid (done),
        .res       (r)
    );

    assign result.r_x = r[0];
    assign result.r_y = r[1];
    assign result.r_z = r[2];
    assign result.r_w = r[3];

endmodule

/* design/qnp_checker.sv */
// Port-level checks for the normalized quaternion product core.
`timescale 1ns / 1ps
module qnp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  qnp_pkg::out_word_t  result
);

    // each accepted word returns after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(qnp_pkg::TOTAL_LAT) done)
        else $error("result word missing after fixed latency");

    // a strobe needs a word accepted at the matching edge
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n, qnp_pkg::TOTAL_LAT))
            |-> $past(start && !busy, qnp_pkg::TOTAL_LAT))
        else $error("result word without a matching start");

    // result components lie within the Q1.14 unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.r_x <= 16384 && result.r_x >= -16384 &&
                  result.r_y <= 16384 && result.r_y >= -16384 &&
                  result.r_z <= 16384 && result.r_z >= -16384 &&
                  result.r_w <= 16384 && result.r_w >= -16384))
        else $error("result component outside Q1.14 unit range");

    // a purely scalar result is plus or minus one
    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.r_x == 0 && result.r_y == 0 && result.r_z == 0)
            |-> (result.r_w == 16384 || result.r_w == -16384))
        else $error("scalar result is not of unit length");

endmodule

bind normalized_quaternion_product_core qnp_checker u_qnp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
